FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// all macros sample on the rising edge of clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, held off during reset
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle, held off during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle, also while reset is high
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/mbp_pkg.sv
// shared types and constants of the msb-first bit packer
// no dependencies
`timescale 1ns / 1ps

package mbp_pkg;

   localparam int MaxFieldBits = 64;
   localparam int ValueWidth   = 64;
   localparam int CountWidth   = 7;
   localparam int PendWidth    = 7;
   localparam int StreamWidth  = ValueWidth + 16;
   localparam int LeftWidth    = 4;

   typedef enum logic [1:0] {
      PadNone   = 2'd0,
      PadBefore = 2'd1,
      PadAfter  = 2'd2,
      PadSpare  = 2'd3
   } pad_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [ValueWidth-1:0] value_left;  // value bits left-justified
      logic [CountWidth-1:0] count;       // zero for an ignored item
      logic                  pad_before;
      logic                  pad_after;
      logic                  flush;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_in_run;
   } rsp_type;

endpackage

FILE: sv/mbp_front.sv
// front end: checks the bit count, normalizes pad mode, left-justifies the value
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_front (
   input  logic [mbp_pkg::ValueWidth-1:0] value,
   input  logic [mbp_pkg::CountWidth-1:0] bit_count,
   input  logic [1:0]                     pad_mode,
   input  logic                           flush,
   output mbp_pkg::cmd_type               cmd
);

   logic                           count_ok;
   logic [mbp_pkg::CountWidth-1:0] shift_amt;
   logic [mbp_pkg::ValueWidth-1:0] value_left;

   always_comb begin
      count_ok   = (bit_count != '0) &&
                   (bit_count <= mbp_pkg::CountWidth'(mbp_pkg::MaxFieldBits));
      shift_amt  = mbp_pkg::CountWidth'(mbp_pkg::ValueWidth) - bit_count;
      value_left = value << shift_amt[5:0];
   end

   always_comb begin
      cmd.value_left = count_ok ? value_left : '0;
      cmd.count      = count_ok ? bit_count : '0;
      cmd.pad_before = count_ok && (pad_mode == mbp_pkg::PadBefore);
      cmd.pad_after  = count_ok && (pad_mode == mbp_pkg::PadAfter);
      cmd.flush      = flush;
   end

endmodule

FILE: sv/mbp_cmd_queue.sv
// two-entry command queue between front and back
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq,
   input  mbp_pkg::cmd_type enq_cmd,
   output logic             full,
   input  logic             deq,
   output logic             deq_valid,
   output mbp_pkg::cmd_type deq_cmd
);

   mbp_pkg::cmd_type slot0_ff, slot0_in;
   mbp_pkg::cmd_type slot1_ff, slot1_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      case ({enq, deq})
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               slot0_in = enq_cmd;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = enq_cmd;
            end
         end
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               slot0_in = enq_cmd;
            end else begin
               slot1_in = enq_cmd;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            cnt_in   = cnt_ff - 2'd1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq_cmd   = slot0_ff;

endmodule

FILE: sv/mbp_back.sv
// back end: merges pending bits with a command, emits one byte a cycle while
// its two-word result buffer has room; depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mbp_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   output mbp_pkg::rsp_type rsp,
   input  logic             rsp_take
);

   localparam int SW = mbp_pkg::StreamWidth;
   localparam int PW = mbp_pkg::PendWidth;
   localparam int LW = mbp_pkg::LeftWidth;

   logic [SW-1:0] stream_ff, stream_in;
   logic [LW-1:0] left_ff, left_in;
   logic [2:0]    rem_ff, rem_in;
   logic          flushed_ff, flushed_in;

   mbp_pkg::rsp_type ob0_ff, ob0_in, ob1_ff, ob1_in;
   logic [1:0]       ocnt_ff, ocnt_in;

   logic             emit;
   logic             load;
   mbp_pkg::rsp_type emit_word;
   logic [PW-1:0]    pend_bits;
   logic [2:0]       pend_cnt;
   logic [7:0]       sum;
   logic [2:0]       pad_bits;
   logic [3:0]       lead;
   logic [7:0]       total;
   logic [SW-1:0]    new_stream;
   logic             new_flush;

   assign emit = (left_ff != '0) && (ocnt_ff != 2'd2);
   assign load = cmd_valid && ((left_ff == '0) || ((left_ff == LW'(1)) && emit));
   assign cmd_take = load;

   // bits left over once the current command has emitted all its bytes
   always_comb begin
      if (flushed_ff) begin
         pend_bits = '0;
         pend_cnt  = '0;
      end else begin
         pend_bits = (left_ff == '0) ? stream_ff[SW-1 -: PW] : stream_ff[SW-9 -: PW];
         pend_cnt  = rem_ff;
      end
   end

   always_comb begin
      sum      = 8'(pend_cnt) + 8'(cmd.count);
      pad_bits = (cmd.pad_before || cmd.pad_after) ? (3'd0 - sum[2:0]) : 3'd0;
      lead     = 4'(pend_cnt) + (cmd.pad_before ? 4'(pad_bits) : 4'd0);
      total    = sum + 8'(pad_bits);
      new_stream = ({cmd.value_left, 16'd0} >> lead) | {pend_bits, {(SW-PW){1'b0}}};
      new_flush  = cmd.flush && (total[2:0] != 3'd0);
   end

   always_comb begin
      emit_word.out_byte    = stream_ff[SW-1 -: 8];
      emit_word.last_in_run = (left_ff == LW'(1));
   end

   always_comb begin
      stream_in  = stream_ff;
      left_in    = left_ff;
      rem_in     = rem_ff;
      flushed_in = flushed_ff;
      if (emit) begin
         stream_in = stream_ff << 8;
         left_in   = left_ff - LW'(1);
      end
      if (load) begin
         stream_in  = new_stream;
         left_in    = LW'(total[6:3]) + LW'(new_flush);
         rem_in     = total[2:0];
         flushed_in = new_flush;
      end
   end

   // result buffer, head in ob0
   always_comb begin
      ob0_in  = ob0_ff;
      ob1_in  = ob1_ff;
      ocnt_in = ocnt_ff;
      case ({emit, rsp_take})
         2'b11: begin
            if (ocnt_ff == 2'd1) begin
               ob0_in = emit_word;
            end else begin
               ob0_in = ob1_ff;
               ob1_in = emit_word;
            end
         end
         2'b10: begin
            if (ocnt_ff == 2'd0) begin
               ob0_in = emit_word;
            end else begin
               ob1_in = emit_word;
            end
            ocnt_in = ocnt_ff + 2'd1;
         end
         2'b01: begin
            ob0_in  = ob1_ff;
            ocnt_in = ocnt_ff - 2'd1;
         end
         default: begin
            ocnt_in = ocnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ob0_ff <= ob0_in;
      ob1_ff <= ob1_in;
      if (reset) begin
         stream_ff  <= '0;
         left_ff    <= '0;
         rem_ff     <= '0;
         flushed_ff <= 1'b0;
         ocnt_ff    <= '0;
      end else begin
         stream_ff  <= stream_in;
         left_ff    <= left_in;
         rem_ff     <= rem_in;
         flushed_ff <= flushed_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   assign rsp_valid = (ocnt_ff != 2'd0);
   assign rsp       = ob0_ff;

endmodule

FILE: sv/msb_first_bit_packer.sv
// msb-first bit packer: appends 1..64-bit values to a byte stream and
// emits each completed byte; top level over front, command queue, back
// depends on mbp_pkg, mbp_front, mbp_cmd_queue, mbp_back
//
// input channel: a word is taken on a rising edge with push high and full
// low. it carries value, bit_count, pad_mode and flush. a bit count of zero
// or above 64 appends nothing, but its flush still acts.
// result channel: while empty is low the oldest byte sits on rsp_out_byte,
// with rsp_last_in_run marking the last byte produced by one input word;
// it is taken on a rising edge with pop high and empty low.
// a taken word goes through the command queue, the stream register and the
// result buffer before its first byte shows. throughput: the back end emits
// one byte per cycle while the result buffer has room (up to nine per word,
// a full 64-bit field takes eight); a word that emits nothing still loads on
// its own; the next word loads in the cycle of the previous word's last byte.
// the single byte-wide emit path sets this rate. a two-entry command queue
// and a two-entry result buffer let the sides stall independently; with pop
// held low the buffer fills and the back end waits, then the queue fills and
// full rises. reset clears the pending bits and both queues; empty is high
// and full low from the cycle after reset.
`timescale 1ns / 1ps

module msb_first_bit_packer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [mbp_pkg::ValueWidth-1:0] req_value,
   input  logic [mbp_pkg::CountWidth-1:0] req_bit_count,
   input  logic [1:0]                     req_pad_mode,
   input  logic                           req_flush,
   output logic                           empty,
   input  logic                           pop,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last_in_run
);

   mbp_pkg::cmd_type front_cmd;
   mbp_pkg::cmd_type queue_cmd;
   mbp_pkg::rsp_type back_rsp;
   logic             queue_valid;
   logic             queue_take;
   logic             rsp_valid;
   logic             enq;

   assign enq = push && !full;

   mbp_front u_front (
      .value     (req_value),
      .bit_count (req_bit_count),
      .pad_mode  (req_pad_mode),
      .flush     (req_flush),
      .cmd       (front_cmd)
   );

   mbp_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .enq_cmd   (front_cmd),
      .full      (full),
      .deq       (queue_take),
      .deq_valid (queue_valid),
      .deq_cmd   (queue_cmd)
   );

   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_take  (queue_take),
      .rsp_valid (rsp_valid),
      .rsp       (back_rsp),
      .rsp_take  (pop && rsp_valid)
   );

   assign empty           = !rsp_valid;
   assign rsp_out_byte    = back_rsp.out_byte;
   assign rsp_last_in_run = back_rsp.last_in_run;

endmodule

FILE: sv/mbp_checker.sv
// port-level checks of the bit packer, bound to the top level
// depends on assert_macros.svh and msb_first_bit_packer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_in_run
);

   // reset leaves no result waiting and room for input
   `ASSERT_NEXT_ALWAYS(a_reset_empty, reset, empty)
   `ASSERT_NEXT_ALWAYS(a_reset_not_full, reset, !full)

   // the queue only fills on an accepted word
   `ASSERT_NOW(a_full_needs_push, $rose(full), $past(push))

   // a waiting word that is not taken holds
   `ASSERT_NEXT(a_rsp_hold, !empty && !pop,
      !empty && $stable(rsp_out_byte) && $stable(rsp_last_in_run))

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
   .clock           (clock),
   .reset           (reset),
   .push            (push),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_in_run (rsp_last_in_run)
);

FILE: tb/msb_first_bit_packer_tb.sv
// testbench for msb_first_bit_packer: drives words, predicts the byte stream
// and checks every emitted byte against the prediction
// depends on mbp_pkg and msb_first_bit_packer
`timescale 1ns / 1ps

module msb_first_bit_packer_tb;

   logic                           clock;
   logic                           reset;
   logic                           push;
   logic                           full;
   logic [mbp_pkg::ValueWidth-1:0] req_value;
   logic [mbp_pkg::CountWidth-1:0] req_bit_count;
   logic [1:0]                     req_pad_mode;
   logic                           req_flush;
   logic                           empty;
   logic                           pop;
   logic [7:0]                     rsp_out_byte;
   logic                           rsp_last_in_run;

   // predicted stream state and expected bytes
   logic [mbp_pkg::PendWidth-1:0] pend_bits;
   logic [2:0]                    pend_cnt;
   logic [7:0]                    word_bytes[$];
   mbp_pkg::rsp_type              byte_q[$];

   int  errors;
   int  hold_request;
   bit  idle_on;

   msb_first_bit_packer dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_value       (req_value),
      .req_bit_count   (req_bit_count),
      .req_pad_mode    (req_pad_mode),
      .req_flush       (req_flush),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_in_run (rsp_last_in_run)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic append_bit(input logic b);
      if (pend_cnt == 3'd7) begin
         word_bytes.push_back({pend_bits, b});
         pend_bits = '0;
         pend_cnt  = '0;
      end else begin
         pend_bits = {pend_bits[mbp_pkg::PendWidth-2:0], b};
         pend_cnt  = pend_cnt + 3'd1;
      end
   endtask

   task automatic predict_bytes(input logic [mbp_pkg::ValueWidth-1:0] v,
                                input logic [mbp_pkg::CountWidth-1:0] cnt,
                                input mbp_pkg::pad_type pad, input logic fl);
      int               pad_bits;
      int               rem;
      logic [7:0]       tail;
      mbp_pkg::rsp_type r;
      word_bytes.delete();
      if (cnt >= 1 && cnt <= mbp_pkg::MaxFieldBits) begin
         pad_bits = 0;
         rem = (int'(pend_cnt) + int'(cnt)) % 8;
         if (pad != mbp_pkg::PadNone && rem != 0)
            pad_bits = 8 - rem;
         if (pad == mbp_pkg::PadBefore)
            repeat (pad_bits) append_bit(1'b0);
         for (int i = int'(cnt) - 1; i >= 0; i--)
            append_bit(v[i]);
         if (pad == mbp_pkg::PadAfter)
            repeat (pad_bits) append_bit(1'b0);
      end
      if (fl && pend_cnt != 0) begin
         tail = 8'(pend_bits);
         word_bytes.push_back(tail << (8 - int'(pend_cnt)));
         pend_bits = '0;
         pend_cnt  = '0;
      end
      foreach (word_bytes[i]) begin
         r.out_byte    = word_bytes[i];
         r.last_in_run = (i == word_bytes.size() - 1);
         byte_q.push_back(r);
      end
   endtask

   // offers one word and returns in the step it is taken
   task automatic send_word(input logic [mbp_pkg::ValueWidth-1:0] v,
                            input logic [mbp_pkg::CountWidth-1:0] cnt,
                            input mbp_pkg::pad_type pad, input logic fl);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      push          <= 1'b1;
      req_value     <= v;
      req_bit_count <= cnt;
      req_pad_mode  <= pad;
      req_flush     <= fl;
      do @(posedge clock); while (full);
      predict_bytes(v, cnt, pad, fl);
   endtask

   task automatic send_random_word();
      logic [mbp_pkg::ValueWidth-1:0] v;
      logic [mbp_pkg::CountWidth-1:0] cnt;
      mbp_pkg::pad_type               pad;
      int                             pick;
      v    = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick == 0)
         cnt = ($urandom_range(0, 1) == 0) ? '0 :
               mbp_pkg::CountWidth'($urandom_range(65, 127));
      else if (pick < 4)
         cnt = mbp_pkg::CountWidth'(mbp_pkg::MaxFieldBits);
      else
         cnt = mbp_pkg::CountWidth'($urandom_range(1, mbp_pkg::MaxFieldBits));
      pad = ($urandom_range(0, 9) == 0) ? mbp_pkg::PadSpare :
            mbp_pkg::pad_type'($urandom_range(0, 2));
      send_word(v, cnt, pad, $urandom_range(0, 4) == 0);
   endtask

   // result side: checks each taken byte, then decides pop for the next edge
   initial begin
      int stall_left;
      stall_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (byte_q.size() == 0) begin
               $display("%0t: unexpected word out_byte %h last_in_run %b",
                        $time, rsp_out_byte, rsp_last_in_run);
               errors++;
            end else begin
               if (rsp_out_byte !== byte_q[0].out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, byte_q[0].out_byte, rsp_out_byte);
                  errors++;
               end
               if (rsp_last_in_run !== byte_q[0].last_in_run) begin
                  $display("%0t: last_in_run expected %b actual %b",
                           $time, byte_q[0].last_in_run, rsp_last_in_run);
                  errors++;
               end
               void'(byte_q.pop_front());
            end
         end
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic test_directed();
      idle_on = 1'b1;
      send_word(64'h1, 7'd1, mbp_pkg::PadNone, 1'b0);
      send_word('1, 7'd64, mbp_pkg::PadNone, 1'b0);
      send_word('0, 7'd64, mbp_pkg::PadAfter, 1'b0);          // nine bytes out
      send_word(64'hFF, 7'd8, mbp_pkg::PadBefore, 1'b0);      // already aligned
      send_word(64'hA5, 7'd8, mbp_pkg::PadAfter, 1'b1);       // aligned, flush with nothing pending
      send_word(64'h5, 7'd3, mbp_pkg::PadNone, 1'b0);
      send_word(64'h3, 7'd2, mbp_pkg::PadBefore, 1'b0);
      send_word(64'h1F, 7'd5, mbp_pkg::PadAfter, 1'b0);
      send_word(64'h2, 7'd2, mbp_pkg::PadSpare, 1'b0);        // spare pad acts as none
      send_word('1, 7'd0, mbp_pkg::PadAfter, 1'b1);           // zero count, flush still acts
      send_word('1, 7'd65, mbp_pkg::PadBefore, 1'b0);         // count too large
      send_word('1, 7'd127, mbp_pkg::PadNone, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FF80, 7'd7, mbp_pkg::PadNone, 1'b1);
      send_word(64'h8000_0000_0000_0001, 7'd64, mbp_pkg::PadBefore, 1'b1);
      send_word(64'h1, 7'd1, mbp_pkg::PadNone, 1'b0);
      send_word('1, 7'd64, mbp_pkg::PadBefore, 1'b1);         // seven zeros in front
      send_word(64'h0123_4567_89AB_CDEF, 7'd63, mbp_pkg::PadNone, 1'b1);
      send_word('1, 7'd7, mbp_pkg::PadNone, 1'b0);
      send_word('1, 7'd1, mbp_pkg::PadNone, 1'b0);
      send_word('0, 7'd64, mbp_pkg::PadNone, 1'b1);
      send_word(64'h5555_5555_5555_5555, 7'd33, mbp_pkg::PadAfter, 1'b1);
   endtask

   // result side stops long enough for both queues to fill and full to rise
   task automatic test_back_pressure();
      idle_on      = 1'b0;
      hold_request = 80;
      repeat (24) send_word({$urandom, $urandom}, 7'd64,
                            mbp_pkg::pad_type'($urandom_range(0, 2)),
                            1'($urandom_range(0, 1)));
   endtask

   task automatic test_random_words();
      for (int i = 0; i < 180; i++) begin
         idle_on = ((i / 30) % 3) != 2;
         send_random_word();
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      repeat (44) send_random_word();
      send_word({$urandom, $urandom}, mbp_pkg::CountWidth'($urandom_range(1, 7)),
                mbp_pkg::PadNone, 1'b1);
   endtask

   initial begin
      errors        = 0;
      hold_request  = 0;
      idle_on       = 1'b0;
      pend_bits     = '0;
      pend_cnt      = '0;
      reset         <= 1'b1;
      push          <= 1'b0;
      req_value     <= '0;
      req_bit_count <= '0;
      req_pad_mode  <= mbp_pkg::PadNone;
      req_flush     <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_pressure();
      test_random_words();
      test_steady_stream();
      push <= 1'b0;
      while (byte_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && byte_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
